// ===== src/dbp_pkg.sv =====
package dbp_pkg;

	localparam int MAX_WIDTH      = 4096;
	localparam int MAX_DOWNSAMPLE = 16;

	localparam int CNT_W   = $clog2(MAX_WIDTH);
	localparam int PH_W    = (MAX_DOWNSAMPLE > 1) ? $clog2(MAX_DOWNSAMPLE) : 1;
	localparam int WIDTH_W = 13;
	localparam int DS_W    = 5;
	localparam int RW_W    = (CNT_W + 1 > WIDTH_W) ? CNT_W + 1 : WIDTH_W;
	localparam int RD_W    = (PH_W + 1 > DS_W) ? PH_W + 1 : DS_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int CENTER_W   = 16;
	localparam int INV_W      = 24;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 120;

	localparam int DIFF_W     = (CNT_W + 4 > CENTER_W) ? CNT_W + 4 : CENTER_W;
	localparam int DEPTH_M_W  = 31;
	localparam int M_W        = DIFF_W + DEPTH_M_W;
	localparam int LOW_BITS   = 24;
	localparam int MH_W       = M_W - LOW_BITS;
	localparam int HI_W       = MH_W + INV_W;
	localparam int LO_W       = LOW_BITS + INV_W;
	localparam int SUM_W      = LO_W + 1;
	localparam int FRAC_SHIFT = 28;
	localparam int FR_W       = SUM_W - FRAC_SHIFT;
	localparam int HI_SHIFT   = 4;
	localparam int R_W        = ((HI_W - HI_SHIFT > FR_W) ? HI_W - HI_SHIFT : FR_W) + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_DOWNSAMPLE   = 3'd1,
		REG_CENTER_X     = 3'd2,
		REG_CENTER_Y     = 3'd3,
		REG_INV_FOCAL_X  = 3'd4,
		REG_INV_FOCAL_Y  = 3'd5,
		REG_MASK_ENABLE  = 3'd6,
		REG_COLOR_ENABLE = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_DEPTH,
		ST_MUL_HIGH,
		ST_MUL_LOW,
		ST_ROUND,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic load;
		logic mul_depth;
		logic mul_high;
		logic mul_low;
		logic round;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic kept;
		logic out_room;
	} status_t;

endpackage

// ===== src/depth_to_point_backprojection.sv =====
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  one depth pixel, tuser frame_start
// m_axis    out        m_axis_tvalid / m_axis_tready  one point, tuser point_valid, tlast row_last
// cfg       in         cfg_we                         register write, cfg_index selects
//
// A pixel that the downsample phases skip is taken in the idle state.
// A kept pixel goes through six steps: the transfer, then depth product, high and low
// reciprocal products on the two lane multipliers, rounding and the output load.
// The output register lets the next pixel transfer while a point waits.
// Reset is asynchronous and active low; it restores the register defaults.
// A stalled output holds the controller in its final step.
module depth_to_point_backprojection (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dbp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dbp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// depth[31:0], depth_finite[32], keep_mask[33], blue_in[41:34], green_in[49:42],
	// red_in[57:50], zero fill above.
	input  logic [dbp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// frame_start[0].
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// coord_x[31:0], coord_y[63:32], coord_z[95:64], red_out[103:96],
	// green_out[111:104], blue_out[119:112].
	output logic [dbp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// point_valid[0].
	output logic                             m_axis_tuser,
	output logic                             m_axis_tlast
);

	dbp_pkg::cmd_t    cmd;
	dbp_pkg::status_t status;

	dbp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	dbp_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd           (cmd),
		.status        (status),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_kept_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && status.kept) |=> !s_axis_tready)
		else $error("input still ready after a kept pixel transfer");

	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output register loaded while a point is waiting");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("invalid point carries nonzero data");

endmodule

// ===== src/dbp_raster.sv =====
module dbp_raster (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         frame_start,
	input  logic [dbp_pkg::WIDTH_W-1:0]  image_width,
	input  logic [dbp_pkg::DS_W-1:0]     downsample,
	output logic [dbp_pkg::CNT_W-1:0]    column,
	output logic [dbp_pkg::CNT_W-1:0]    row,
	output logic                         kept,
	output logic                         row_last
);

	logic [dbp_pkg::CNT_W-1:0] column_q, row_q;
	logic [dbp_pkg::PH_W-1:0]  column_phase_q, row_phase_q;
	logic [dbp_pkg::PH_W-1:0]  column_phase, row_phase;
	logic [dbp_pkg::RW_W-1:0]  width_raw, width_lim;
	logic [dbp_pkg::RD_W-1:0]  ds_raw, ds_lim;
	logic                      wrap;
	logic                      column_phase_wrap, row_phase_wrap;

	always_comb begin
		width_raw = dbp_pkg::RW_W'(image_width);
		if (width_raw == '0) begin
			width_lim = dbp_pkg::RW_W'(1);
		end else if (width_raw > dbp_pkg::RW_W'(dbp_pkg::MAX_WIDTH)) begin
			width_lim = dbp_pkg::RW_W'(dbp_pkg::MAX_WIDTH);
		end else begin
			width_lim = width_raw;
		end
		ds_raw = dbp_pkg::RD_W'(downsample);
		if (ds_raw == '0) begin
			ds_lim = dbp_pkg::RD_W'(1);
		end else if (ds_raw > dbp_pkg::RD_W'(dbp_pkg::MAX_DOWNSAMPLE)) begin
			ds_lim = dbp_pkg::RD_W'(dbp_pkg::MAX_DOWNSAMPLE);
		end else begin
			ds_lim = ds_raw;
		end
	end

	assign column       = frame_start ? '0 : column_q;
	assign row          = frame_start ? '0 : row_q;
	assign column_phase = frame_start ? '0 : column_phase_q;
	assign row_phase    = frame_start ? '0 : row_phase_q;

	assign kept     = (column_phase == '0) && (row_phase == '0);
	assign row_last = (dbp_pkg::RW_W'(column) + dbp_pkg::RW_W'(ds_lim)) >= width_lim;
	assign wrap     = (dbp_pkg::RW_W'(column) + dbp_pkg::RW_W'(1)) >= width_lim;

	assign column_phase_wrap = (dbp_pkg::RD_W'(column_phase) + dbp_pkg::RD_W'(1)) >= ds_lim;
	assign row_phase_wrap    = (dbp_pkg::RD_W'(row_phase) + dbp_pkg::RD_W'(1)) >= ds_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q       <= '0;
			row_q          <= '0;
			column_phase_q <= '0;
			row_phase_q    <= '0;
		end else if (advance) begin
			if (wrap) begin
				column_q       <= '0;
				column_phase_q <= '0;
				row_q          <= row + dbp_pkg::CNT_W'(1);
				row_phase_q    <= row_phase_wrap ? '0 : row_phase + dbp_pkg::PH_W'(1);
			end else begin
				column_q       <= column + dbp_pkg::CNT_W'(1);
				column_phase_q <= column_phase_wrap ? '0 : column_phase + dbp_pkg::PH_W'(1);
				row_q          <= row;
				row_phase_q    <= row_phase;
			end
		end
	end

endmodule

// ===== src/dbp_datapath.sv =====
module dbp_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dbp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dbp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [dbp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  logic                             s_axis_tuser,
	input  dbp_pkg::cmd_t                    cmd,
	output dbp_pkg::status_t                 status,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [dbp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tuser,
	output logic                             m_axis_tlast
);

	logic [dbp_pkg::WIDTH_W-1:0]  image_width_q;
	logic [dbp_pkg::DS_W-1:0]     downsample_q;
	logic [dbp_pkg::CENTER_W-1:0] center_q [2];
	logic [dbp_pkg::INV_W-1:0]    inv_q [2];
	logic                         mask_enable_q, color_enable_q;

	logic [dbp_pkg::CNT_W-1:0] column, row;
	logic                      kept, row_last;

	logic [31:0] in_depth;
	logic        in_finite, in_keep, in_valid;
	logic [23:0] in_color;

	logic [dbp_pkg::DIFF_W-1:0] pos_ext [2];
	logic [dbp_pkg::DIFF_W-1:0] ctr_ext [2];

	logic [31:0]                 depth_q;
	logic                        valid_q, row_last_q;
	logic [23:0]                 color_q;
	logic [dbp_pkg::DIFF_W-1:0]  mag_q [2];
	logic [1:0]                  neg_q;
	logic [dbp_pkg::M_W-1:0]     m_q [2];
	logic [dbp_pkg::HI_W-1:0]    hi_q [2];
	logic [dbp_pkg::LO_W-1:0]    lo_q [2];
	logic [dbp_pkg::FR_W-1:0]    frac_q [2];
	logic [dbp_pkg::SUM_W-1:0]   frac_sum [2];
	logic [dbp_pkg::R_W-1:0]     r_val [2];
	logic [31:0]                 coord [2];

	logic        out_valid_q;
	logic [dbp_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic        out_user_q, out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= dbp_pkg::WIDTH_W'(640);
			downsample_q   <= dbp_pkg::DS_W'(1);
			center_q[0]    <= dbp_pkg::CENTER_W'(5120);
			center_q[1]    <= dbp_pkg::CENTER_W'(3840);
			inv_q[0]       <= dbp_pkg::INV_W'(33554);
			inv_q[1]       <= dbp_pkg::INV_W'(33554);
			mask_enable_q  <= 1'b0;
			color_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (dbp_pkg::cfg_reg_t'(cfg_index))
				dbp_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[dbp_pkg::WIDTH_W-1:0];
				dbp_pkg::REG_DOWNSAMPLE:   downsample_q   <= cfg_data[dbp_pkg::DS_W-1:0];
				dbp_pkg::REG_CENTER_X:     center_q[0]    <= cfg_data[dbp_pkg::CENTER_W-1:0];
				dbp_pkg::REG_CENTER_Y:     center_q[1]    <= cfg_data[dbp_pkg::CENTER_W-1:0];
				dbp_pkg::REG_INV_FOCAL_X:  inv_q[0]       <= cfg_data[dbp_pkg::INV_W-1:0];
				dbp_pkg::REG_INV_FOCAL_Y:  inv_q[1]       <= cfg_data[dbp_pkg::INV_W-1:0];
				dbp_pkg::REG_MASK_ENABLE:  mask_enable_q  <= cfg_data[0];
				dbp_pkg::REG_COLOR_ENABLE: color_enable_q <= cfg_data[0];
			endcase
		end
	end

	dbp_raster u_raster (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (cmd.take),
		.frame_start (s_axis_tuser),
		.image_width (image_width_q),
		.downsample  (downsample_q),
		.column      (column),
		.row         (row),
		.kept        (kept),
		.row_last    (row_last)
	);

	assign in_depth  = s_axis_tdata[31:0];
	assign in_finite = s_axis_tdata[32];
	assign in_keep   = s_axis_tdata[33];
	assign in_color  = s_axis_tdata[57:34];
	assign in_valid  = in_finite && !in_depth[31] && (in_depth != '0)
		&& !(mask_enable_q && !in_keep);

	assign pos_ext[0] = dbp_pkg::DIFF_W'({column, 4'b0000});
	assign pos_ext[1] = dbp_pkg::DIFF_W'({row, 4'b0000});
	assign ctr_ext[0] = dbp_pkg::DIFF_W'(center_q[0]);
	assign ctr_ext[1] = dbp_pkg::DIFF_W'(center_q[1]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			depth_q    <= in_depth;
			valid_q    <= in_valid;
			row_last_q <= row_last;
			color_q    <= (in_valid && color_enable_q) ? in_color : '0;
			for (int l = 0; l < 2; l++) begin
				neg_q[l] <= pos_ext[l] < ctr_ext[l];
				mag_q[l] <= (pos_ext[l] < ctr_ext[l]) ? ctr_ext[l] - pos_ext[l]
					: pos_ext[l] - ctr_ext[l];
			end
		end
		for (int l = 0; l < 2; l++) begin
			if (cmd.mul_depth) begin
				m_q[l] <= dbp_pkg::M_W'(mag_q[l])
					* dbp_pkg::M_W'(depth_q[dbp_pkg::DEPTH_M_W-1:0]);
			end
			if (cmd.mul_high) begin
				hi_q[l] <= dbp_pkg::HI_W'(m_q[l][dbp_pkg::M_W-1:dbp_pkg::LOW_BITS])
					* dbp_pkg::HI_W'(inv_q[l]);
			end
			if (cmd.mul_low) begin
				lo_q[l] <= dbp_pkg::LO_W'(m_q[l][dbp_pkg::LOW_BITS-1:0])
					* dbp_pkg::LO_W'(inv_q[l]);
			end
			if (cmd.round) begin
				frac_q[l] <= frac_sum[l][dbp_pkg::SUM_W-1:dbp_pkg::FRAC_SHIFT];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			frac_sum[l] = dbp_pkg::SUM_W'(lo_q[l])
				+ (dbp_pkg::SUM_W'(1) << (dbp_pkg::FRAC_SHIFT - 1))
				+ (dbp_pkg::SUM_W'(hi_q[l][dbp_pkg::HI_SHIFT-1:0]) << dbp_pkg::LOW_BITS);
			r_val[l] = dbp_pkg::R_W'(hi_q[l][dbp_pkg::HI_W-1:dbp_pkg::HI_SHIFT])
				+ dbp_pkg::R_W'(frac_q[l]);
			if (!valid_q) begin
				coord[l] = '0;
			end else if (!neg_q[l]) begin
				coord[l] = (r_val[l] > dbp_pkg::R_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
					: r_val[l][31:0];
			end else begin
				coord[l] = (r_val[l] >= dbp_pkg::R_W'(32'h8000_0000)) ? 32'h8000_0000
					: 32'd0 - r_val[l][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {color_q[7:0], color_q[15:8], color_q[23:16],
				valid_q ? depth_q : 32'd0, coord[1], coord[0]};
			out_user_q <= valid_q;
			out_last_q <= row_last_q;
		end
	end

	assign status.kept     = kept;
	assign status.out_room = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== src/dbp_ctrl.sv =====
module dbp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  dbp_pkg::status_t status,
	output dbp_pkg::cmd_t    cmd
);

	dbp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dbp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dbp_pkg::ST_IDLE: begin
				if (s_axis_tvalid && status.kept) begin
					state_d = dbp_pkg::ST_MUL_DEPTH;
				end
			end
			dbp_pkg::ST_MUL_DEPTH: state_d = dbp_pkg::ST_MUL_HIGH;
			dbp_pkg::ST_MUL_HIGH:  state_d = dbp_pkg::ST_MUL_LOW;
			dbp_pkg::ST_MUL_LOW:   state_d = dbp_pkg::ST_ROUND;
			dbp_pkg::ST_ROUND:     state_d = dbp_pkg::ST_EMIT;
			dbp_pkg::ST_EMIT: begin
				if (status.out_room) begin
					state_d = dbp_pkg::ST_IDLE;
				end
			end
			default: state_d = dbp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == dbp_pkg::ST_IDLE);
		cmd           = '0;
		cmd.take      = s_axis_tready && s_axis_tvalid;
		cmd.load      = s_axis_tready && s_axis_tvalid && status.kept;
		cmd.mul_depth = (state_q == dbp_pkg::ST_MUL_DEPTH);
		cmd.mul_high  = (state_q == dbp_pkg::ST_MUL_HIGH);
		cmd.mul_low   = (state_q == dbp_pkg::ST_MUL_LOW);
		cmd.round     = (state_q == dbp_pkg::ST_ROUND);
		cmd.emit      = (state_q == dbp_pkg::ST_EMIT) && status.out_room;
	end

endmodule

// ===== tb/sv/depth_to_point_backprojection_test.sv =====
`timescale 1ns / 100ps

module depth_to_point_backprojection_test;

	localparam int CYCLE_LIMIT = 100_000;
	localparam int RANDOM_PHASES = 8;
	localparam int PIXELS_PER_PHASE = 45;
	localparam int TALL_PIXELS = 40;

	typedef struct packed {
		logic [31:0] depth;
		logic        finite;
		logic        keep;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic        frame_start;
	} pixel_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        row_last;
	} point_t;

	class backprojection_board;
		logic [12:0] width_reg;
		logic [4:0]  ds_reg;
		logic [15:0] center_x, center_y;
		logic [23:0] inv_x, inv_y;
		logic        mask_on, color_on;
		logic [11:0] column, row;
		logic [3:0]  column_phase, row_phase;
		point_t      expected_points[$];
		int          mismatches, pixels_seen, points_seen, valid_points;

		function new();
			width_reg = 13'd640;
			ds_reg = 5'd1;
			center_x = 16'd5120;
			center_y = 16'd3840;
			inv_x = 24'd33554;
			inv_y = 24'd33554;
			mask_on = 1'b0;
			color_on = 1'b0;
			column = '0;
			row = '0;
			column_phase = '0;
			row_phase = '0;
		endfunction

		function void write_reg(dbp_pkg::cfg_reg_t idx, logic [23:0] value);
			case (idx)
				dbp_pkg::REG_IMAGE_WIDTH:  width_reg = value[12:0];
				dbp_pkg::REG_DOWNSAMPLE:   ds_reg = value[4:0];
				dbp_pkg::REG_CENTER_X:     center_x = value[15:0];
				dbp_pkg::REG_CENTER_Y:     center_y = value[15:0];
				dbp_pkg::REG_INV_FOCAL_X:  inv_x = value;
				dbp_pkg::REG_INV_FOCAL_Y:  inv_y = value;
				dbp_pkg::REG_MASK_ENABLE:  mask_on = value[0];
				dbp_pkg::REG_COLOR_ENABLE: color_on = value[0];
				default: ;
			endcase
		endfunction

		// Offset in sixteenths of a pixel times depth times the reciprocal, then
		// the magnitude is rounded half away from zero and saturated to Q16.16.
		function logic [31:0] project_axis(logic [11:0] pos, logic [15:0] center,
				logic [31:0] depth, logic [23:0] inv);
			logic signed [17:0] offset;
			logic [16:0]        span;
			logic [79:0]        scaled;
			logic [79:0]        rounded;
			offset = $signed({2'b00, pos, 4'b0000}) - $signed({2'b00, center});
			span = 17'(offset[17] ? -offset : offset);
			scaled = 80'(span) * 80'(depth) * 80'(inv);
			rounded = (scaled + (80'd1 << 27)) >> 28;
			if (!offset[17])
				return (rounded > 80'h7FFF_FFFF) ? 32'h7FFF_FFFF : rounded[31:0];
			if (rounded >= 80'h8000_0000)
				return 32'h8000_0000;
			return -rounded[31:0];
		endfunction

		function void take_pixel(pixel_t p);
			int     w, ds;
			point_t e;
			w = (width_reg == 0) ? 1 : (width_reg > dbp_pkg::MAX_WIDTH) ? dbp_pkg::MAX_WIDTH
				: int'(width_reg);
			ds = (ds_reg == 0) ? 1 : (ds_reg > dbp_pkg::MAX_DOWNSAMPLE)
				? dbp_pkg::MAX_DOWNSAMPLE : int'(ds_reg);
			pixels_seen++;
			if (p.frame_start) begin
				column = '0;
				row = '0;
				column_phase = '0;
				row_phase = '0;
			end
			if (column_phase == 0 && row_phase == 0) begin
				e = '0;
				if (p.finite && !p.depth[31] && p.depth != 0 && !(mask_on && !p.keep)) begin
					e.valid = 1'b1;
					e.x = project_axis(column, center_x, p.depth, inv_x);
					e.y = project_axis(row, center_y, p.depth, inv_y);
					e.z = p.depth;
					if (color_on) begin
						e.red = p.red;
						e.green = p.green;
						e.blue = p.blue;
					end
				end
				e.row_last = (int'(column) + ds >= w);
				expected_points.insert(expected_points.size(), e);
			end
			// A column past a shrunken width wraps on this pixel as well.
			if (int'(column) + 1 >= w) begin
				column = '0;
				column_phase = '0;
				row = row + 12'd1;
				row_phase = (int'(row_phase) + 1 >= ds) ? 4'd0 : row_phase + 4'd1;
			end else begin
				column = column + 12'd1;
				column_phase = (int'(column_phase) + 1 >= ds) ? 4'd0 : column_phase + 4'd1;
			end
		endfunction

		task log_mismatch(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			mismatches++;
		endtask

		task compare_field(string field, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				log_mismatch($sformatf("point %0d %s: got %h, expected %h",
					points_seen, field, got, want));
		endtask

		task check_point(point_t got);
			point_t e;
			if (expected_points.size() == 0) begin
				log_mismatch("point transfer with no pending pixel");
				return;
			end
			e = expected_points.pop_front();
			points_seen++;
			if (e.valid)
				valid_points++;
			compare_field("point_valid", 32'(got.valid), 32'(e.valid));
			compare_field("coord_x", got.x, e.x);
			compare_field("coord_y", got.y, e.y);
			compare_field("coord_z", got.z, e.z);
			compare_field("red_out", 32'(got.red), 32'(e.red));
			compare_field("green_out", 32'(got.green), 32'(e.green));
			compare_field("blue_out", 32'(got.blue), 32'(e.blue));
			compare_field("row_last", 32'(got.row_last), 32'(e.row_last));
		endtask
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [dbp_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [dbp_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [dbp_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic                            s_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [dbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                            m_axis_tuser;
	logic                            m_axis_tlast;

	backprojection_board board = new();
	point_t              seen_point;
	int                  cycles;
	int                  stall_mode;
	int                  burst_left;
	bit                  steady;

	depth_to_point_backprojection dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic pixel_t px(logic [31:0] depth, logic finite, logic keep,
			logic [7:0] blue, logic [7:0] green, logic [7:0] red, logic frame);
		pixel_t p;
		p.depth = depth;
		p.finite = finite;
		p.keep = keep;
		p.blue = blue;
		p.green = green;
		p.red = red;
		p.frame_start = frame;
		return p;
	endfunction

	function automatic pixel_t random_pixel(logic frame);
		logic [31:0] depth;
		case ($urandom_range(0, 9))
			0: depth = 32'd0;
			1: depth = {1'b1, 31'($urandom)};
			2: depth = $urandom;
			3: depth = $urandom_range(1, 32'h0000_FFFF);
			default: depth = $urandom_range(32'h0000_8000, 32'h00FF_FFFF);
		endcase
		return px(depth, $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)),
			8'($urandom), 8'($urandom), 8'($urandom), frame);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d points pending.",
				cycles, board.expected_points.size());
			$display("Test completed with failures");
			$finish;
		end
		if (cycles % 96 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 4) == 0);
			default: m_axis_tready <= (cycles % 24 >= 18);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.take_pixel(px(s_axis_tdata[31:0], s_axis_tdata[32], s_axis_tdata[33],
					s_axis_tdata[41:34], s_axis_tdata[49:42], s_axis_tdata[57:50],
					s_axis_tuser));
			if (m_axis_tvalid && m_axis_tready) begin
				seen_point = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
					m_axis_tdata[95:64], m_axis_tdata[103:96], m_axis_tdata[111:104],
					m_axis_tdata[119:112], m_axis_tlast};
				board.check_point(seen_point);
			end
		end
	end

	task send_pixel(input pixel_t p);
		int gap;
		if (!steady && burst_left <= 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, p.red, p.green, p.blue, p.keep, p.finite, p.depth};
		s_axis_tuser <= p.frame_start;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
	endtask

	task wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.expected_points.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task put_reg(input dbp_pkg::cfg_reg_t idx, input logic [23:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		board.write_reg(idx, value);
	endtask

	task set_config(input logic [12:0] width, input logic [4:0] ds,
			input logic [15:0] cx, input logic [15:0] cy,
			input logic [23:0] ix, input logic [23:0] iy,
			input logic mask, input logic color);
		put_reg(dbp_pkg::REG_IMAGE_WIDTH, 24'(width));
		put_reg(dbp_pkg::REG_DOWNSAMPLE, 24'(ds));
		put_reg(dbp_pkg::REG_CENTER_X, 24'(cx));
		put_reg(dbp_pkg::REG_CENTER_Y, 24'(cy));
		put_reg(dbp_pkg::REG_INV_FOCAL_X, ix);
		put_reg(dbp_pkg::REG_INV_FOCAL_Y, iy);
		put_reg(dbp_pkg::REG_MASK_ENABLE, 24'(mask));
		put_reg(dbp_pkg::REG_COLOR_ENABLE, 24'(color));
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [12:0] width;
		logic [4:0]  ds;
		logic [15:0] cx, cy;
		logic [23:0] ix, iy;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cycles = 0;
		stall_mode = 0;
		burst_left = 0;
		steady = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Depth extremes, every invalid cause, both saturation directions and a
		// frame restart in the middle of a row.
		set_config(13'd5, 5'd1, 16'd40, 16'd24, 24'hFF_FFFF, 24'd1, 1'b1, 1'b1);
		send_pixel(px(32'h7FFF_FFFF, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		send_pixel(px(32'h0000_0000, 1'b1, 1'b1, 8'h12, 8'h34, 8'h56, 1'b0));
		send_pixel(px(32'h8000_0000, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0));
		send_pixel(px(32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 8'h00, 8'hFF, 1'b0));
		send_pixel(px(32'h0001_0000, 1'b0, 1'b1, 8'h80, 8'h80, 8'h80, 1'b0));
		send_pixel(px(32'h0001_0000, 1'b1, 1'b0, 8'h77, 8'h66, 8'h55, 1'b0));
		send_pixel(px(32'h0000_0001, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0));
		send_pixel(px(32'h0123_4567, 1'b1, 1'b1, 8'h00, 8'hA5, 8'h5A, 1'b0));
		send_pixel(px(32'h0040_0000, 1'b1, 1'b1, 8'hC3, 8'h3C, 8'h01, 1'b0));
		send_pixel(px(32'h7FFF_FFFF, 1'b1, 1'b1, 8'hFE, 8'h7F, 8'h80, 1'b0));
		send_pixel(px(32'h0002_0000, 1'b1, 1'b1, 8'h11, 8'h22, 8'h33, 1'b0));
		send_pixel(px(32'h0003_0000, 1'b1, 1'b1, 8'h44, 8'h55, 8'h66, 1'b0));
		send_pixel(px(32'h0004_8000, 1'b1, 1'b1, 8'h99, 8'hAA, 8'hBB, 1'b1));
		wait_idle();

		// Zero width and downsample act as one; zero reciprocal; mask and color off.
		set_config(13'd0, 5'd0, 16'hFFFF, 16'hFFFF, 24'd0, 24'hFF_FFFF, 1'b0, 1'b0);
		send_pixel(px(32'h7FFF_FFFF, 1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		send_pixel(px(32'h0001_0000, 1'b1, 1'b1, 8'h5A, 8'hA5, 8'h0F, 1'b0));
		send_pixel(px(32'h0000_0001, 1'b1, 1'b0, 8'h01, 8'h02, 8'h03, 1'b0));
		send_pixel(px(32'h7FFF_0000, 1'b1, 1'b1, 8'hF0, 8'h0F, 8'hFF, 1'b0));
		wait_idle();

		// Oversized width and downsample clamp; the row is left unfinished.
		set_config(13'h1FFF, 5'h1F, 16'd0, 16'd0, 24'h80_0000, 24'h80_0000, 1'b1, 1'b1);
		send_pixel(px(32'h0010_0000, 1'b1, 1'b1, 8'h10, 8'h20, 8'h30, 1'b1));
		repeat (5) send_pixel(random_pixel(1'b0));
		wait_idle();

		// Shrinking the width wraps the stale column on the next pixel.
		set_config(13'd3, 5'd2, 16'd8, 16'd8, 24'h10_0000, 24'h10_0000, 1'b0, 1'b1);
		repeat (6) send_pixel(random_pixel(1'b0));
		wait_idle();

		// One pixel per row with the largest downsample, so every sixteenth row
		// gives a point.
		set_config(13'd1, 5'd16, 16'd100, 16'd0, 24'h00_1000, 24'h00_0100, 1'b0, 1'b1);
		send_pixel(random_pixel(1'b1));
		repeat (TALL_PIXELS - 1) send_pixel(random_pixel(1'b0));
		wait_idle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 9))
				0: width = 13'($urandom_range(0, 13'h1FFF));
				1: width = 13'd1;
				default: width = 13'($urandom_range(2, 12));
			endcase
			ds = 5'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
				: $urandom_range(1, 3));
			cx = 16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 200));
			cy = 16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 200));
			ix = 24'($urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 20));
			iy = 24'($urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 20));
			set_config(width, ds, cx, cy, ix, iy, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			steady = (phase % 3 == 2);
			send_pixel(random_pixel(1'($urandom_range(0, 1))));
			repeat (PIXELS_PER_PHASE - 1)
				send_pixel(random_pixel($urandom_range(0, 39) == 0));
			wait_idle();
		end

		$display("Checked %0d point transfers (%0d valid) from %0d pixel transfers.",
			board.points_seen, board.valid_points, board.pixels_seen);
		$display("Runs covered clamped and zero settings, a width shrink and %0d random setups.",
			RANDOM_PHASES);
		if (board.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
